>>> rtl/i2svs_pkg.sv
// Package for the I2S volume serialiser: payload structs and fixed constants.
// No dependencies; imported by every module of the block.
package i2svs_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned VOLUME_W   = 7;
  localparam int unsigned MAG_W      = SAMPLE_W + VOLUME_W; // |sample| * volume
  localparam int unsigned RECIP_SH   = MAG_W + 1;            // reciprocal scale 2^24
  localparam int unsigned POS_W      = 6;                    // 64 bit positions a frame
  localparam int unsigned QUEUE_DEPTH = 2;

  // One stereo frame as it enters the block
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } frame_in_t;

  // One bit-clock result
  typedef struct packed {
    logic word_select;
    logic data_bit;
    logic frame_last;
  } bit_out_t;

  // Scaled frame handed from the front end to the serialiser
  typedef struct packed {
    logic [SAMPLE_W-1:0] left_word;
    logic [SAMPLE_W-1:0] right_word;
  } scaled_pair_t;

endpackage

>>> rtl/i2svs_front.sv
// Front end: volume register, request intake and six-stage scaling pipeline.
// Depends on i2svs_pkg; feeds i2svs_queue.
module i2svs_front #(
  parameter int unsigned VOLUME_MAX = 100
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [6:0]              cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  i2svs_pkg::frame_in_t    in_data_i,
  output logic                    push_valid_o,
  input  logic                    push_stall_i,
  output i2svs_pkg::scaled_pair_t push_data_o
);
  import i2svs_pkg::*;

  localparam int unsigned PROD_W = MAG_W + 8;
  localparam logic [VOLUME_W-1:0] VOL_RESET =
    VOLUME_W'((VOLUME_MAX < 100) ? VOLUME_MAX : 100);
  localparam logic [7:0] DIV_L = 8'(VOLUME_MAX);
  localparam logic [RECIP_SH:0] RECIP = (RECIP_SH+1)'((1 << RECIP_SH) / VOLUME_MAX);

  logic [VOLUME_W-1:0] volume_q, volume_d;
  logic [5:0] vld_q;
  logic       adv;

  logic signed [1:0][SAMPLE_W-1:0] smp_q;
  logic [1:0][MAG_W-1:0]           mag2_q, mag3_q, mag4_q;
  logic [1:0]                      neg2_q, neg3_q, neg4_q, neg5_q;
  logic [1:0][MAG_W-1:0]           q0_3_q, q0_4_q, quo5_q;
  logic [1:0][PROD_W-1:0]          prod4_q;
  logic [1:0][SAMPLE_W-1:0]        res6_q;

  logic [1:0][MAG_W-1:0]           mag2_d, q0_3_d, quo5_d;
  logic [1:0][PROD_W-1:0]          prod4_d;
  logic [1:0][SAMPLE_W-1:0]        res6_d;

  // Volume write with clamp to maximum
  always_comb begin
    volume_d = volume_q;
    if (cfg_we_i) begin
      if ({1'b0, cfg_wdata_i} > DIV_L) begin
        volume_d = VOLUME_W'(VOLUME_MAX);
      end else begin
        volume_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= VOL_RESET;
    end else begin
      volume_q <= volume_d;
    end
  end

  // Whole pipeline moves unless the last stage cannot push
  assign adv        = !vld_q[5] || !push_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  // Per-lane datapath, lanes are independent
  always_comb begin
    logic [SAMPLE_W-1:0]   abs_s;
    logic [2*MAG_W+1:0]    recip_p;
    logic [PROD_W-1:0]     rem;
    for (int l = 0; l < 2; l++) begin
      // stage 2: magnitude of sample times volume
      abs_s     = smp_q[l][SAMPLE_W-1] ? SAMPLE_W'(-smp_q[l]) : smp_q[l];
      mag2_d[l] = MAG_W'(abs_s) * MAG_W'(volume_q);
      // stage 3: quotient estimate by reciprocal, low by at most one
      recip_p   = (2*MAG_W+2)'(mag2_q[l]) * (2*MAG_W+2)'(RECIP);
      q0_3_d[l] = recip_p[RECIP_SH +: MAG_W];
      // stage 4: back-multiply estimate
      prod4_d[l] = PROD_W'(q0_3_q[l]) * PROD_W'(DIV_L);
      // stage 5: remainder correction
      rem        = {8'b0, mag4_q[l]} - prod4_q[l];
      quo5_d[l]  = (rem >= PROD_W'(DIV_L)) ? q0_4_q[l] + MAG_W'(1) : q0_4_q[l];
      // stage 6: restore sign and saturate
      if (neg5_q[l]) begin
        res6_d[l] = (quo5_q[l] > MAG_W'(32768)) ? 16'h8000 : SAMPLE_W'(-quo5_q[l]);
      end else begin
        res6_d[l] = (quo5_q[l] > MAG_W'(32767)) ? 16'h7fff : quo5_q[l][SAMPLE_W-1:0];
      end
    end
  end

  // Stage payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp_q[0] <= in_data_i.left_sample;
      smp_q[1] <= in_data_i.right_sample;
      mag2_q   <= mag2_d;
      neg2_q   <= {smp_q[1][SAMPLE_W-1], smp_q[0][SAMPLE_W-1]};
      mag3_q   <= mag2_q;
      neg3_q   <= neg2_q;
      q0_3_q   <= q0_3_d;
      q0_4_q   <= q0_3_q;
      mag4_q   <= mag3_q;
      neg4_q   <= neg3_q;
      prod4_q  <= prod4_d;
      quo5_q   <= quo5_d;
      neg5_q   <= neg4_q;
      res6_q   <= res6_d;
    end
  end

  assign push_valid_o           = vld_q[5];
  assign push_data_o.left_word  = res6_q[0];
  assign push_data_o.right_word = res6_q[1];

  // Stall only ever comes from a blocked last stage
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld_q[5] && push_stall_i))
    else $error("front stalls without a blocked push");

  // Volume never exceeds maximum
  a_volume_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, volume_q} <= DIV_L)
    else $error("volume above maximum");

endmodule

>>> rtl/i2svs_queue.sv
// Two-entry queue of scaled frames between front end and serialiser.
// Depends on i2svs_pkg.
module i2svs_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_valid_i,
  output logic                    push_stall_o,
  input  i2svs_pkg::scaled_pair_t push_data_i,
  output logic                    pop_valid_o,
  input  logic                    pop_i,
  output i2svs_pkg::scaled_pair_t pop_data_o
);
  import i2svs_pkg::*;

  scaled_pair_t entry_q [QUEUE_DEPTH];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q, count_d;
  logic         push, pop;

  assign push_stall_o = (count_q == 2'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(QUEUE_DEPTH))
    else $error("queue overfilled");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == 2'd0) || (count_q == 2'(QUEUE_DEPTH))) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

>>> rtl/i2svs_back.sv
// Serialiser: turns one scaled frame into 64 bit-clock results.
// Depends on i2svs_pkg; pulls frames from i2svs_queue.
module i2svs_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_valid_i,
  output logic                    pop_o,
  input  i2svs_pkg::scaled_pair_t pop_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output i2svs_pkg::bit_out_t     out_data_o
);
  import i2svs_pkg::*;

  localparam logic [POS_W-1:0] POS_LAST = '1;

  logic                busy_q, busy_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [SAMPLE_W-1:0] left_q, right_q;
  logic                out_valid_q, out_valid_d;
  bit_out_t            out_q, out_d;
  logic                adv;
  logic [SAMPLE_W-1:0] word;
  logic [4:0]          chan_pos;
  logic [3:0]          bit_idx;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = pop_valid_i && (!busy_q || (adv && pos_q == POS_LAST));

  // Bit for the current position: delay bit, 16 data bits MSB first, padding
  assign word     = pos_q[POS_W-1] ? right_q : left_q;
  assign chan_pos = pos_q[4:0];
  assign bit_idx  = 4'(5'd16 - chan_pos);

  always_comb begin
    busy_d      = busy_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      if (busy_q) begin
        out_valid_d       = 1'b1;
        out_d.word_select = pos_q[POS_W-1];
        out_d.data_bit    = ((chan_pos != 5'd0) && (chan_pos <= 5'd16)) ? word[bit_idx] : 1'b0;
        out_d.frame_last  = (pos_q == POS_LAST);
        pos_d             = pos_q + POS_W'(1);
        if (pos_q == POS_LAST) begin
          busy_d = 1'b0;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Frame words and output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      left_q  <= pop_data_i.left_word;
      right_q <= pop_data_i.right_word;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_last_is_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_last) |-> out_data_o.word_select)
    else $error("frame end flagged on left channel");

  a_mid_frame_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && pos_q != '0) |-> out_valid_q)
    else $error("output dropped inside a frame");

endmodule

>>> rtl/i2s_volume_serializer_unit.sv
// I2S volume serialiser, top level: front end, frame queue and serialiser.
// Depends on i2svs_pkg, i2svs_front, i2svs_queue and i2svs_back.
//
// Each request is one stereo frame of signed 16-bit samples. Both samples are
// scaled by volume/VOLUME_MAX (truncated toward zero, saturated to 16 bits) in
// a six-stage pipeline, then queued (two frames deep) and serialised as 64
// bit-clock results: left with word_select low, then right with it high, each
// as one zero delay bit, 16 data bits MSB first and 15 zero padding bits;
// frame_last marks the 64th. The serialiser emits one result per cycle while
// out_stall_i is low, so that output loop sets the sustained frame rate; it
// pops the next frame as the last result of the current one goes out. Volume
// writes above VOLUME_MAX clamp to it.
module i2s_volume_serializer_unit #(
  parameter int unsigned VOLUME_MAX = 100
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  i2svs_pkg::frame_in_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2svs_pkg::bit_out_t  out_data_o
);
  import i2svs_pkg::*;

  logic         push_valid, push_stall;
  scaled_pair_t push_data;
  logic         pop_valid, pop;
  scaled_pair_t pop_data;

  i2svs_front #(
    .VOLUME_MAX(VOLUME_MAX)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_stall_i (push_stall),
    .push_data_o  (push_data)
  );

  i2svs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  i2svs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
